[design/gaussian_splat_alpha_blend_macros.svh]
// Assertion macros used by the blend back end.
`ifndef GAUSSIAN_SPLAT_ALPHA_BLEND_MACROS_SVH
`define GAUSSIAN_SPLAT_ALPHA_BLEND_MACROS_SVH

// checked only outside reset
`define GSAB_CHECK(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// checked on every edge, reset included
`define GSAB_CHECK_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[design/gsab_pkg.sv]
// Types, constants and exp table function for the splat blender.
`default_nettype none
package gsab_pkg;

  localparam logic [16:0] ONE_Q16        = 17'h10000;
  localparam logic [15:0] ALPHA_MAX      = 16'd64880;
  // alpha*255 < 1.0 exactly when alpha < 258
  localparam logic [15:0] ALPHA_WEAK_MIN = 16'd258;
  // p*10000 < 2^32 exactly when p < 429497
  localparam logic [33:0] TRANS_FLOOR    = 34'd429497;
  localparam int          NUM_RGB        = 3;

  localparam logic [1:0] REG_BG_RED   = 2'd0;
  localparam logic [1:0] REG_BG_GREEN = 2'd1;
  localparam logic [1:0] REG_BG_BLUE  = 2'd2;

  typedef struct packed {
    logic        func;
    logic [15:0] opacity;
    logic [2:0][15:0] col;
  } carry_t;

  typedef struct packed {
    logic        func;
    logic        skip;
    logic [15:0] alpha;
    logic [2:0][15:0] col;
  } item_t;

  // exp(-x) for x in Q.30 (x = 8*i/N): Taylor of exp(-x/16), squared 4 times, Q0.16
  function automatic logic [15:0] exp_q16(input logic [63:0] x);
    logic [63:0] y;
    logic [63:0] term;
    logic [63:0] s;
    logic [63:0] v;
    longint      sum;
    y    = x >> 4;
    sum  = longint'(64'd1 << 30);
    term = 64'd1 << 30;
    term = ((term * y) >> 30);      sum = sum - longint'(term);
    term = ((term * y) >> 30) / 2;  sum = sum + longint'(term);
    term = ((term * y) >> 30) / 3;  sum = sum - longint'(term);
    term = ((term * y) >> 30) / 4;  sum = sum + longint'(term);
    term = ((term * y) >> 30) / 5;  sum = sum - longint'(term);
    term = ((term * y) >> 30) / 6;  sum = sum + longint'(term);
    term = ((term * y) >> 30) / 7;  sum = sum - longint'(term);
    term = ((term * y) >> 30) / 8;  sum = sum + longint'(term);
    term = ((term * y) >> 30) / 9;  sum = sum - longint'(term);
    term = ((term * y) >> 30) / 10; sum = sum + longint'(term);
    term = ((term * y) >> 30) / 11; sum = sum - longint'(term);
    term = ((term * y) >> 30) / 12; sum = sum + longint'(term);
    s = (sum > 0) ? 64'(sum) : 64'd0;
    s = (s * s) >> 30;
    s = (s * s) >> 30;
    s = (s * s) >> 30;
    s = (s * s) >> 30;
    v = (s + 64'd8192) >> 14;
    return (v > 64'd65535) ? 16'hFFFF : v[15:0];
  endfunction

endpackage
`default_nettype wire

[design/gsab_front.sv]
// Front end: falloff, exp lookup, alpha and skip classification, pipelined.
`default_nettype none
module gsab_front import gsab_pkg::*; #(
  parameter int EXP_TABLE_ENTRIES = 256
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               func,
  input  wire logic        [11:0] pix_x,
  input  wire logic        [11:0] pix_y,
  input  wire logic signed [16:0] mean_x,
  input  wire logic signed [16:0] mean_y,
  input  wire logic signed [23:0] conic_a,
  input  wire logic signed [23:0] conic_b,
  input  wire logic signed [23:0] conic_c,
  input  wire logic        [15:0] opacity,
  input  wire logic        [15:0] col_red,
  input  wire logic        [15:0] col_green,
  input  wire logic        [15:0] col_blue,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output item_t                   item
);

  localparam int IW = $clog2(EXP_TABLE_ENTRIES);

  logic [15:0] rom [EXP_TABLE_ENTRIES];
  for (genvar g = 0; g < EXP_TABLE_ENTRIES; g++) begin : g_rom
    localparam logic [63:0] X = (64'(g) << 33) / EXP_TABLE_ENTRIES;
    assign rom[g] = exp_q16(X);
  end

  logic [6:0] v;
  carry_t     cr [6];
  logic       adv;

  logic signed [17:0] dx1, dy1, dx2, dy2;
  logic signed [23:0] a1, b1, c1;
  logic signed [41:0] ax, bx, cy;
  logic signed [59:0] qa, qb, qc;
  logic signed [61:0] qsum;
  logic               neg4, far4, neg5, far5, skip6;
  logic        [30:0] t31;
  logic        [63:0] iprod;
  logic        [IW-1:0] idx;
  logic        [15:0] e;
  logic        [31:0] araw;
  logic        [15:0] acap;

  assign adv       = !v[6] || out_ready;
  assign in_ready  = adv;
  assign out_valid = v[6];

  assign qsum  = 62'(qa) + 62'(qc) + (62'(qb) <<< 1);
  assign iprod = 64'(t31) * 64'(EXP_TABLE_ENTRIES);
  assign araw  = 32'(cr[5].opacity) * 32'(e);
  assign acap  = (araw[31:16] > ALPHA_MAX) ? ALPHA_MAX : araw[31:16];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (adv) begin
      v <= {v[5:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cr[0] <= '{func: func, opacity: opacity, col: {col_blue, col_green, col_red}};
      for (int i = 1; i < 6; i++) cr[i] <= cr[i-1];
      dx1 <= 18'(mean_x) - $signed({1'b0, pix_x, 4'b0000});
      dy1 <= 18'(mean_y) - $signed({1'b0, pix_y, 4'b0000});
      a1  <= conic_a;
      b1  <= conic_b;
      c1  <= conic_c;
      ax  <= a1 * dx1;
      bx  <= b1 * dx1;
      cy  <= c1 * dy1;
      dx2 <= dx1;
      dy2 <= dy1;
      qa  <= ax * dx2;
      qb  <= bx * dy2;
      qc  <= cy * dy2;
      neg4 <= qsum[61];
      far4 <= |qsum[60:32];
      t31  <= qsum[31:1];
      neg5 <= neg4;
      far5 <= far4;
      idx  <= iprod[31 +: IW];
      e     <= rom[idx];
      skip6 <= neg5 || far5;
      item.func  <= cr[5].func;
      item.col   <= cr[5].col;
      item.alpha <= acap;
      item.skip  <= skip6 || (acap < ALPHA_WEAK_MIN);
    end
  end

endmodule
`default_nettype wire

[design/gsab_queue.sv]
// Short item queue between the front end and the blend back end.
`default_nettype none
module gsab_queue import gsab_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire item_t in_item,
  output logic       out_valid,
  input  wire logic  out_ready,
  output item_t      out_item
);

  item_t      slots [4];
  logic [1:0] wr_ptr, rd_ptr;
  logic [2:0] count;
  logic       push, pop;

  assign in_ready  = (count != 3'd4);
  assign out_valid = (count != 3'd0);
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 2'd1;
      if (pop)  rd_ptr <= rd_ptr + 2'd1;
      count <= count + 3'(push) - 3'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= in_item;
  end

endmodule
`default_nettype wire

[design/gsab_back.sv]
// Back end: transmittance recurrence, colour accumulation and pixel result.
`default_nettype none
module gsab_back import gsab_pkg::*; #(
  parameter int CHANNELS   = 3,
  parameter int COUNT_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire item_t       in_item,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      out_red,
  output logic [15:0]      out_green,
  output logic [15:0]      out_blue,
  output logic [16:0]      final_trans,
  output logic [15:0]      contributors
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_ACC  = 4'b0100,
    ST_END  = 4'b1000
  } state_t;

  state_t          state;
  logic [15:0]     bg [NUM_RGB];
  logic [16:0]     trans;
  logic [31:0]     acc [NUM_RGB];
  logic [31:0]     ca  [NUM_RGB];
  logic [16:0]     add [NUM_RGB];
  logic [16:0]     bgp [NUM_RGB];
  logic [33:0]     p;
  logic [COUNT_BITS-1:0] seen, last_blended;
  logic            sat_done;
  logic            out_free;

  logic [48:0]     mprod [NUM_RGB];
  logic [32:0]     asum  [NUM_RGB];
  logic [32:0]     osum  [NUM_RGB];
  logic [15:0]     osat  [NUM_RGB];
  logic [COUNT_BITS+15:0] lb_ext;

  assign out_free = !m_tvalid || m_tready;
  assign in_ready = (state == ST_IDLE) && (!in_item.func || out_free);
  assign lb_ext   = {16'b0, last_blended};

  always_comb begin
    for (int ch = 0; ch < NUM_RGB; ch++) begin
      mprod[ch] = 49'(ca[ch]) * 49'(trans);
      asum[ch]  = 33'(acc[ch]) + 33'(add[ch]);
      osum[ch]  = ((ch < CHANNELS) ? 33'(acc[ch]) : 33'd0) + 33'(bgp[ch]);
      osat[ch]  = (osum[ch] > 33'd65535) ? 16'hFFFF : osum[ch][15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bg <= '{default: '0};
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BG_RED:   bg[0] <= cfg_data;
        REG_BG_GREEN: bg[1] <= cfg_data;
        REG_BG_BLUE:  bg[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      trans        <= ONE_Q16;
      acc          <= '{default: '0};
      seen         <= '0;
      last_blended <= '0;
      sat_done     <= 1'b0;
      m_tvalid     <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (in_valid && in_ready) begin
            if (in_item.func) begin
              state <= ST_END;
            end else if (!sat_done) begin
              if (seen != '1) seen <= seen + 1'b1;
              if (!in_item.skip) state <= ST_MUL;
            end
          end
        end
        ST_MUL: begin
          if (p < TRANS_FLOOR) begin
            sat_done <= 1'b1;
            state    <= ST_IDLE;
          end else begin
            state <= ST_ACC;
          end
        end
        ST_ACC: begin
          for (int ch = 0; ch < NUM_RGB; ch++) begin
            if (ch < CHANNELS)
              acc[ch] <= asum[ch][32] ? 32'hFFFF_FFFF : asum[ch][31:0];
          end
          trans        <= p[32:16];
          last_blended <= seen;
          state        <= ST_IDLE;
        end
        ST_END: begin
          m_tvalid     <= 1'b1;
          trans        <= ONE_Q16;
          acc          <= '{default: '0};
          seen         <= '0;
          last_blended <= '0;
          sat_done     <= 1'b0;
          state        <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      p <= 34'(trans) * 34'(ONE_Q16 - 17'(in_item.alpha));
      for (int ch = 0; ch < NUM_RGB; ch++) begin
        ca[ch]  <= 32'(in_item.col[ch]) * 32'(in_item.alpha);
        bgp[ch] <= 17'((33'(trans) * 33'(bg[ch])) >> 16);
      end
    end
    if (state == ST_MUL) begin
      for (int ch = 0; ch < NUM_RGB; ch++) add[ch] <= mprod[ch][48:32];
    end
    if (state == ST_END) begin
      out_red      <= osat[0];
      out_green    <= osat[1];
      out_blue     <= osat[2];
      final_trans  <= trans;
      contributors <= (lb_ext > (COUNT_BITS+16)'(65535)) ? 16'hFFFF : lb_ext[15:0];
    end
  end

`include "gaussian_splat_alpha_blend_macros.svh"

  `GSAB_CHECK(a_trans_max, trans <= ONE_Q16, "transmittance above one")
  `GSAB_CHECK(a_end_slot_free, (state == ST_END) |-> !m_tvalid, "result slot busy at end")
  `GSAB_CHECK(a_done_holds, (sat_done && $past(sat_done) && !$past(rst)) |-> $stable(trans), "trans moved after stop")
  `GSAB_CHECK(a_blend_counts, (state == ST_ACC) |=> (last_blended == $past(seen)), "last blended not recorded")

endmodule
`default_nettype wire

[design/gaussian_splat_alpha_blend.sv]
// Top level of the front-to-back Gaussian splat alpha blender.
`default_nettype none
// Blends depth-sorted Gaussians onto one pixel. A front pipeline of seven
// stages works out the falloff, the table exp and alpha for each request and
// writes it to a four-entry queue; the back end pops the queue and runs the
// transmittance recurrence. A skipped or ignored Gaussian is taken in the
// idle state alone, one that hits the transmittance floor also passes the
// multiply state, a blended one the multiply and accumulate states, and an
// end request the end state; the result sits in an output register.
module gaussian_splat_alpha_blend import gsab_pkg::*; #(
  parameter int CHANNELS          = 3,
  parameter int EXP_TABLE_ENTRIES = 256,
  parameter int COUNT_BITS        = 16
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_we,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [15:0]  cfg_data,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // pix_x, pix_y, mean_x, mean_y, conic_a, conic_b, conic_c, opacity,
  // col_red, col_green, col_blue, zero fill
  input  wire logic [199:0] s_tdata,
  // func
  input  wire logic         s_tuser,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // out_red, out_green, out_blue, final_trans, contributors, zero fill
  output logic [87:0]       m_tdata
);

  logic  q_in_valid, q_in_ready, q_out_valid, q_out_ready;
  item_t q_in_item, q_out_item;
  logic [15:0] out_red, out_green, out_blue, contributors;
  logic [16:0] final_trans;

  gsab_front #(.EXP_TABLE_ENTRIES(EXP_TABLE_ENTRIES)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .func      (s_tuser),
    .pix_x     (s_tdata[11:0]),
    .pix_y     (s_tdata[23:12]),
    .mean_x    ($signed(s_tdata[40:24])),
    .mean_y    ($signed(s_tdata[57:41])),
    .conic_a   ($signed(s_tdata[81:58])),
    .conic_b   ($signed(s_tdata[105:82])),
    .conic_c   ($signed(s_tdata[129:106])),
    .opacity   (s_tdata[145:130]),
    .col_red   (s_tdata[161:146]),
    .col_green (s_tdata[177:162]),
    .col_blue  (s_tdata[193:178]),
    .out_valid (q_in_valid),
    .out_ready (q_in_ready),
    .item      (q_in_item)
  );

  gsab_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (q_in_valid),
    .in_ready  (q_in_ready),
    .in_item   (q_in_item),
    .out_valid (q_out_valid),
    .out_ready (q_out_ready),
    .out_item  (q_out_item)
  );

  gsab_back #(.CHANNELS(CHANNELS), .COUNT_BITS(COUNT_BITS)) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (q_out_valid),
    .in_ready     (q_out_ready),
    .in_item      (q_out_item),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .out_red      (out_red),
    .out_green    (out_green),
    .out_blue     (out_blue),
    .final_trans  (final_trans),
    .contributors (contributors)
  );

  assign m_tdata = {7'b0, contributors, final_trans, out_blue, out_green, out_red};

endmodule
`default_nettype wire
